// ===== hdl/phdc_pkg.sv =====
package phdc_pkg;

	// input word: one control-task pass, optionally with a sensor reply
	typedef struct packed {
		logic        func;
		logic [31:0] now_ms;
		logic [7:0]  reply_address;
		logic [7:0]  reply_function;
		logic [7:0]  reply_count;
		logic [31:0] reply_value_bits;
	} in_word_t;

	// result word: pump state and parse outcome after the pass
	typedef struct packed {
		logic        pump_on;
		logic [1:0]  pump_event;
		logic [1:0]  parse_status;
		logic [15:0] measured_ph;
	} out_word_t;

	// classification handed from the front end to the back end
	typedef struct packed {
		logic       ph_load;
		logic [1:0] status;
	} parse_info_t;

	localparam int INFO_W = $bits(parse_info_t);

	// parse status codes
	localparam logic [1:0] ST_NONE       = 2'd0;
	localparam logic [1:0] ST_ACCEPTED   = 2'd1;
	localparam logic [1:0] ST_BAD_HEADER = 2'd2;
	localparam logic [1:0] ST_RANGE      = 2'd3;

	// pump event codes
	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_STOP   = 2'd1;
	localparam logic [1:0] EV_ACID   = 2'd2;
	localparam logic [1:0] EV_ALKALI = 2'd3;

	// register indexes
	localparam logic [7:0] REG_SETPOINT = 8'd0;
	localparam logic [7:0] REG_DEADBAND = 8'd1;
	localparam logic [7:0] REG_RUN_MS   = 8'd2;
	localparam logic [7:0] REG_COOL_MS  = 8'd3;

	// register reset values
	localparam logic [15:0] SETPOINT_RST = 16'd28672;
	localparam logic [15:0] DEADBAND_RST = 16'd2048;
	localparam logic [23:0] RUN_MS_RST   = 24'd5000;
	localparam logic [23:0] COOL_MS_RST  = 24'd30000;

	// reply header bytes
	localparam logic [7:0] HDR_ADDRESS  = 8'h01;
	localparam logic [7:0] HDR_FUNCTION = 8'h03;
	localparam logic [7:0] HDR_COUNT    = 8'h04;

	// float limits: 14.0 and negative zero
	localparam logic [31:0] PH_MAX_BITS = 32'h4160_0000;
	localparam logic [31:0] NEG_ZERO    = 32'h8000_0000;

endpackage

// ===== hdl/ph_dosing_pump_controller.sv =====
// pH dosing pump controller. Each input word is one control-task pass with a
// millisecond timestamp and, when func is set, a sensor reply (header 01 03 04
// and a big-endian IEEE single pH). A reply in [0, 14] becomes the stored pH
// in fixed point; the pump then stops after pump_run_ms or, once idle and past
// pump_cooldown_ms, starts when pH leaves setpoint +/- deadband. Every pass
// gives exactly one result word. Throughput is one word per clock while the
// result queue has room: the front end parses a word in the cycle it is
// pushed into a two-entry queue, the back end updates the pump state from the
// queue head into a two-entry result queue, so a result word passes both
// queues before it is on the result ports and can be popped.
// Configuration writes are always ready and take effect on the next cycle;
// write registers only while no pass is in flight.
module ph_dosing_pump_controller #(
	parameter int TIME_WIDTH   = 32,
	parameter int PH_FRAC_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  phdc_pkg::in_word_t   item,
	output logic                 empty,
	input  logic                 pop,
	output phdc_pkg::out_word_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [7:0]           cfg_index,
	input  logic [23:0]          cfg_data
);
	import phdc_pkg::*;

	localparam int PH_W  = PH_FRAC_BITS + 4;
	localparam int MID_W = INFO_W + TIME_WIDTH + PH_W;

	parse_info_t           f_info;
	logic [TIME_WIDTH-1:0] f_now;
	logic [PH_W-1:0]       f_ph;
	logic [MID_W-1:0]      mid_wdata;
	logic [MID_W-1:0]      mid_rdata;
	logic                  mid_empty;
	parse_info_t           b_info;
	logic [TIME_WIDTH-1:0] b_now;
	logic [PH_W-1:0]       b_ph;
	logic                  b_pop;
	logic                  res_full;
	logic                  res_push;
	out_word_t             res_word;

	assign cfg_ready = 1'b1;

	// front end: header and value classification
	phdc_front #(
		.TIME_WIDTH  (TIME_WIDTH),
		.PH_FRAC_BITS(PH_FRAC_BITS)
	) u_front (
		.item(item),
		.info(f_info),
		.now (f_now),
		.ph  (f_ph)
	);

	assign mid_wdata = {f_info, f_now, f_ph};

	// queue between front and back end
	phdc_fifo #(
		.WIDTH(MID_W)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (mid_wdata),
		.full  (full),
		.pop   (b_pop),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	assign {b_info, b_now, b_ph} = mid_rdata;

	// back end: pump timer and deadband decision
	phdc_back #(
		.TIME_WIDTH  (TIME_WIDTH),
		.PH_FRAC_BITS(PH_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_valid  (!mid_empty),
		.q_info   (b_info),
		.q_now    (b_now),
		.q_ph     (b_ph),
		.q_pop    (b_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_word)
	);

	// result queue
	phdc_fifo #(
		.WIDTH($bits(out_word_t))
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_word),
		.full  (res_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule

// ===== hdl/phdc_fifo.sv =====
module phdc_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	// two-entry queue, one word in per cycle while not full and one out while not empty
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/phdc_front.sv =====
module phdc_front #(
	parameter int TIME_WIDTH   = 32,
	parameter int PH_FRAC_BITS = 12
) (
	input  phdc_pkg::in_word_t         item,
	output phdc_pkg::parse_info_t      info,
	output logic [TIME_WIDTH-1:0]      now,
	output logic [PH_FRAC_BITS+3:0]    ph
);
	import phdc_pkg::*;

	localparam int PH_W  = PH_FRAC_BITS + 4;
	localparam int EXT_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
	// right shift for a biased exponent e is BIAS - e
	localparam int BIAS  = 150 - PH_FRAC_BITS;

	logic [EXT_W-1:0] now_ext;
	logic [31:0]      bits;
	logic [7:0]       expo;
	logic [23:0]      sig;
	logic [7:0]       rsh;
	logic [23:0]      shifted;
	logic             hdr_ok;
	logic             neg_zero;
	logic             in_range;

	// timestamp kept modulo 2^TIME_WIDTH
	assign now_ext = EXT_W'(item.now_ms);
	assign now     = now_ext[TIME_WIDTH-1:0];

	// header check
	assign hdr_ok = (item.reply_address == HDR_ADDRESS) &&
		(item.reply_function == HDR_FUNCTION) && (item.reply_count == HDR_COUNT);

	// float range check: [0, 14], negative zero taken as zero
	assign bits     = item.reply_value_bits;
	assign neg_zero = bits == NEG_ZERO;
	assign in_range = neg_zero || (!bits[31] && bits <= PH_MAX_BITS);

	// float to fixed point, truncated toward zero
	always_comb begin
		if (bits[30:23] != 8'd0) begin
			expo = bits[30:23];
			sig  = {1'b1, bits[22:0]};
		end else begin
			expo = 8'd1;
			sig  = {1'b0, bits[22:0]};
		end
		rsh     = 8'(BIAS) - expo;
		shifted = sig >> rsh;
		if (neg_zero) begin
			shifted = 24'd0;
		end
	end
	assign ph = PH_W'(shifted);

	// classification
	always_comb begin
		info.ph_load = 1'b0;
		info.status  = ST_NONE;
		if (item.func) begin
			if (!hdr_ok) begin
				info.status = ST_BAD_HEADER;
			end else if (in_range) begin
				info.status  = ST_ACCEPTED;
				info.ph_load = 1'b1;
			end else begin
				info.status = ST_RANGE;
			end
		end
	end

endmodule

// ===== hdl/phdc_back.sv =====
module phdc_back #(
	parameter int TIME_WIDTH   = 32,
	parameter int PH_FRAC_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [7:0]                 cfg_index,
	input  logic [23:0]                cfg_data,
	input  logic                       q_valid,
	input  phdc_pkg::parse_info_t      q_info,
	input  logic [TIME_WIDTH-1:0]      q_now,
	input  logic [PH_FRAC_BITS+3:0]    q_ph,
	output logic                       q_pop,
	input  logic                       res_full,
	output logic                       res_push,
	output phdc_pkg::out_word_t        res
);
	import phdc_pkg::*;

	localparam int PH_W  = PH_FRAC_BITS + 4;
	localparam int CW    = ((PH_W > 16) ? PH_W : 16) + 1;
	localparam int TCMPW = (TIME_WIDTH > 24) ? TIME_WIDTH : 24;

	logic [15:0]           setpoint_q;
	logic [15:0]           deadband_q;
	logic [23:0]           run_ms_q;
	logic [23:0]           cool_ms_q;
	logic                  running_q;
	logic [TIME_WIDTH-1:0] start_q;
	logic [TIME_WIDTH-1:0] stop_q;
	logic [PH_W-1:0]       ph_q;

	logic [PH_W-1:0]       ph_new;
	logic [TIME_WIDTH-1:0] run_el;
	logic [TIME_WIDTH-1:0] cool_el;
	logic                  run_done;
	logic                  cool_done;
	logic [CW-1:0]         ph_ext;
	logic [CW-1:0]         lo_sum;
	logic [CW-1:0]         hi_sum;
	logic                  want_acid;
	logic                  want_alkali;
	logic                  running_nx;
	logic [1:0]            event_nx;
	logic                  step;

	assign step     = q_valid && !res_full;
	assign q_pop    = step;
	assign res_push = step;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= SETPOINT_RST;
			deadband_q <= DEADBAND_RST;
			run_ms_q   <= RUN_MS_RST;
			cool_ms_q  <= COOL_MS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SETPOINT: setpoint_q <= cfg_data[15:0];
				REG_DEADBAND: deadband_q <= cfg_data[15:0];
				REG_RUN_MS:   run_ms_q   <= cfg_data;
				REG_COOL_MS:  cool_ms_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	// stored pH after this word
	assign ph_new = q_info.ph_load ? q_ph : ph_q;

	// elapsed times, modular
	assign run_el    = q_now - start_q;
	assign cool_el   = q_now - stop_q;
	assign run_done  = TCMPW'(run_el) >= TCMPW'(run_ms_q);
	assign cool_done = TCMPW'(cool_el) >= TCMPW'(cool_ms_q);

	// deadband compare in exact integers
	assign ph_ext      = CW'(ph_new);
	assign lo_sum      = ph_ext + CW'(deadband_q);
	assign hi_sum      = CW'(setpoint_q) + CW'(deadband_q);
	assign want_acid   = lo_sum < CW'(setpoint_q);
	assign want_alkali = ph_ext > hi_sum;

	// pump decision
	always_comb begin
		running_nx = running_q;
		event_nx   = EV_NONE;
		if (running_q) begin
			if (run_done) begin
				running_nx = 1'b0;
				event_nx   = EV_STOP;
			end
		end else if (cool_done) begin
			if (want_acid) begin
				running_nx = 1'b1;
				event_nx   = EV_ACID;
			end else if (want_alkali) begin
				running_nx = 1'b1;
				event_nx   = EV_ALKALI;
			end
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			start_q   <= '0;
			stop_q    <= '0;
			ph_q      <= '0;
		end else if (step) begin
			running_q <= running_nx;
			ph_q      <= ph_new;
			if (event_nx == EV_STOP) begin
				stop_q <= q_now;
			end
			if (event_nx == EV_ACID || event_nx == EV_ALKALI) begin
				start_q <= q_now;
			end
		end
	end

	// result word
	assign res.pump_on      = running_nx;
	assign res.pump_event   = event_nx;
	assign res.parse_status = q_info.status;
	assign res.measured_ph  = ph_ext[15:0];

endmodule

// ===== dv/ph_dosing_pump_checker.sv =====
`timescale 1ns / 100ps

// Watches both word channels and the register port, predicts every pass
// result and compares it with what the controller returns.
module ph_dosing_pump_checker
	import phdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  in_word_t    item,
	input  logic        empty,
	input  logic        pop,
	input  out_word_t   result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          errors,
	output int          pending
);

	localparam int FRAC_BITS  = 12;
	localparam int REPORT_MAX = 10;

	// register copies
	logic [15:0] setpoint;
	logic [15:0] deadband;
	logic [23:0] run_ms;
	logic [23:0] cool_ms;

	// pump state copies
	logic        running;
	logic [31:0] started_at;
	logic [31:0] stopped_at;
	logic [15:0] stored_ph;

	// results still owed by the controller, oldest first
	out_word_t   owed_q[$];

	// [0, 14] including negative zero; NaN and infinities sit above 14.0
	function automatic logic ph_in_range(input logic [31:0] bits);
		return (bits == NEG_ZERO) || (!bits[31] && bits <= PH_MAX_BITS);
	endfunction

	// truncating float to Q4.12; valid values always shift right
	function automatic logic [15:0] ph_to_fixed(input logic [31:0] bits);
		logic [7:0]  expo;
		logic [23:0] mant;
		int          shift;
		expo = bits[30:23];
		mant = {expo != 8'd0, bits[22:0]};
		if (expo == 8'd0)
			expo = 8'd1;
		shift = 150 - FRAC_BITS - int'(expo);
		return 16'(mant >> shift);
	endfunction

	// one control pass: parse the reply, then run the pump timer
	function automatic out_word_t pump_pass(input in_word_t w);
		out_word_t   r;
		logic [31:0] elapsed;
		logic [16:0] ph_plus_band;
		logic [16:0] upper_edge;
		r.parse_status = ST_NONE;
		r.pump_event   = EV_NONE;
		if (w.func) begin
			if (w.reply_address != HDR_ADDRESS || w.reply_function != HDR_FUNCTION ||
			    w.reply_count != HDR_COUNT) begin
				r.parse_status = ST_BAD_HEADER;
			end else if (ph_in_range(w.reply_value_bits)) begin
				stored_ph      = ph_to_fixed(w.reply_value_bits);
				r.parse_status = ST_ACCEPTED;
			end else begin
				r.parse_status = ST_RANGE;
			end
		end
		ph_plus_band = {1'b0, stored_ph} + {1'b0, deadband};
		upper_edge   = {1'b0, setpoint} + {1'b0, deadband};
		if (running) begin
			elapsed = w.now_ms - started_at;
			if (elapsed >= {8'd0, run_ms}) begin
				running      = 1'b0;
				stopped_at   = w.now_ms;
				r.pump_event = EV_STOP;
			end
		end else begin
			elapsed = w.now_ms - stopped_at;
			if (elapsed >= {8'd0, cool_ms}) begin
				if (ph_plus_band < {1'b0, setpoint}) begin
					running      = 1'b1;
					started_at   = w.now_ms;
					r.pump_event = EV_ACID;
				end else if ({1'b0, stored_ph} > upper_edge) begin
					running      = 1'b1;
					started_at   = w.now_ms;
					r.pump_event = EV_ALKALI;
				end
			end
		end
		r.pump_on     = running;
		r.measured_ph = stored_ph;
		return r;
	endfunction

	// sample all three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			setpoint   = SETPOINT_RST;
			deadband   = DEADBAND_RST;
			run_ms     = RUN_MS_RST;
			cool_ms    = COOL_MS_RST;
			running    = 1'b0;
			started_at = '0;
			stopped_at = '0;
			stored_ph  = '0;
			owed_q.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			// returned word against the oldest prediction
			if (pop && !empty) begin
				if (owed_q.size() == 0) begin
					if (errors < REPORT_MAX)
						$display("unexpected result word: on=%0d ev=%0d st=%0d ph=%0d",
							result.pump_on, result.pump_event, result.parse_status,
							result.measured_ph);
					errors <= errors + 1;
				end else begin
					want = owed_q.pop_front();
					if (result.pump_on !== want.pump_on ||
					    result.pump_event !== want.pump_event ||
					    result.parse_status !== want.parse_status ||
					    result.measured_ph !== want.measured_ph) begin
						if (errors < REPORT_MAX)
							$display(
								"mismatch on/ev/st/ph: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								want.pump_on, want.pump_event, want.parse_status,
								want.measured_ph, result.pump_on, result.pump_event,
								result.parse_status, result.measured_ph);
						errors <= errors + 1;
					end
				end
			end
			// accepted pass word
			if (push && !full)
				owed_q.push_back(pump_pass(item));
			// register write, seen by the next pass
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SETPOINT: setpoint = cfg_data[15:0];
					REG_DEADBAND: deadband = cfg_data[15:0];
					REG_RUN_MS:   run_ms   = cfg_data;
					REG_COOL_MS:  cool_ms  = cfg_data;
					default: ;
				endcase
			end
			pending <= owed_q.size();
		end
	end

endmodule

// ===== dv/ph_dosing_pump_controller_tb.sv =====
`timescale 1ns / 100ps

module ph_dosing_pump_controller_tb;
	import phdc_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE      = 4;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        full;
	in_word_t    item      = '0;
	logic        empty;
	logic        pop       = 1'b0;
	out_word_t   result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [23:0] cfg_data  = '0;

	int          errors;
	int          pending;
	int          quiet_cycles = 0;
	int          rx_hold      = 0;
	logic        idle_on      = 1'b1;
	logic [31:0] clock_ms     = '0;

	ph_dosing_pump_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ph_dosing_pump_checker pass_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: random pops, or a long hold when one is requested
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				pop <= idle_on ? ($urandom_range(0, 99) >= 29) : 1'b1;
			end
		end
	end

	// watchdog: too long without any word moving on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("ph_dosing_pump_controller_tb: errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic in_word_t pass_word(input logic f, input logic [31:0] now,
			input logic [7:0] addr, input logic [7:0] fn, input logic [7:0] cnt,
			input logic [31:0] bits);
		in_word_t w;
		w.func             = f;
		w.now_ms           = now;
		w.reply_address    = addr;
		w.reply_function   = fn;
		w.reply_count      = cnt;
		w.reply_value_bits = bits;
		return w;
	endfunction

	// offer one word; each cycle idles with the same chance before it
	task automatic send_pass(input in_word_t w);
		if (idle_on) begin
			while ($urandom_range(0, 99) < 29) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
		push <= 1'b1;
		item <= w;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic send_tick(input logic [31:0] now);
		send_pass(pass_word(1'b0, now, '0, '0, '0, '0));
	endtask

	task automatic send_reply(input logic [31:0] now, input logic [31:0] bits);
		send_pass(pass_word(1'b1, now, HDR_ADDRESS, HDR_FUNCTION, HDR_COUNT, bits));
	endtask

	// mostly in-range pH values, plus raw patterns and the float specials
	function automatic logic [31:0] random_ph_bits();
		logic [31:0] bits;
		logic [7:0]  expo;
		int          pick;
		pick = $urandom_range(0, 19);
		if (pick < 11) begin
			expo = 8'($urandom_range(118, 130));
			bits = {1'b0, expo, 23'($urandom)};
			if (expo == 8'd130)
				bits[22:0] = 23'($urandom_range(0, 23'h60_0000));
		end else if (pick < 14) begin
			bits = $urandom_range(0, PH_MAX_BITS);
		end else if (pick < 17) begin
			bits = $urandom;
		end else begin
			case ($urandom_range(0, 9))
				0:       bits = 32'h7FC0_0000;
				1:       bits = 32'h7F80_0001;
				2:       bits = 32'h7F80_0000;
				3:       bits = 32'hFF80_0000;
				4:       bits = NEG_ZERO;
				5:       bits = PH_MAX_BITS;
				6:       bits = PH_MAX_BITS + 32'd1;
				7:       bits = 32'h0000_0001;
				8:       bits = 32'hBF80_0000;
				default: bits = 32'h0000_0000;
			endcase
		end
		return bits;
	endfunction

	// random pass: clock moves forward by up to step_max, rarely jumps anywhere
	task automatic send_random(input logic [31:0] step_max);
		in_word_t w;
		if ($urandom_range(0, 49) == 0)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + $urandom_range(0, step_max);
		w = pass_word($urandom_range(0, 9) < 7, clock_ms, HDR_ADDRESS, HDR_FUNCTION,
			HDR_COUNT, random_ph_bits());
		if ($urandom_range(0, 4) == 0) begin
			if ($urandom_range(0, 1)) w.reply_address  = 8'($urandom);
			if ($urandom_range(0, 1)) w.reply_function = 8'($urandom);
			if ($urandom_range(0, 1)) w.reply_count    = 8'($urandom);
		end
		send_pass(w);
	endtask

	task automatic send_randoms(input int n, input logic [31:0] step_max);
		for (int i = 0; i < n; i++)
			send_random(step_max);
	endtask

	// stop offering and wait until every owed result is back
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(input logic [7:0] idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// all four registers, written only with the controller idle
	task automatic configure(input logic [23:0] sp, input logic [23:0] band,
			input logic [23:0] run, input logic [23:0] cool);
		drain();
		set_reg(REG_SETPOINT, sp);
		set_reg(REG_DEADBAND, band);
		set_reg(REG_RUN_MS, run);
		set_reg(REG_COOL_MS, cool);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reply parsing under reset registers
		send_tick(32'd0);
		send_reply(32'd10, 32'h40E0_0000);
		send_pass(pass_word(1'b1, 32'd20, 8'h02, HDR_FUNCTION, HDR_COUNT, 32'h3F80_0000));
		send_pass(pass_word(1'b1, 32'd30, HDR_ADDRESS, 8'h06, HDR_COUNT, 32'h3F80_0000));
		send_pass(pass_word(1'b1, 32'd40, HDR_ADDRESS, HDR_FUNCTION, 8'h08, 32'h3F80_0000));
		send_pass(pass_word(1'b0, 32'd50, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
		send_reply(32'd60, 32'h7FC0_0000);
		send_reply(32'd70, 32'h7F80_0000);
		send_reply(32'd80, 32'hBF80_0000);
		send_reply(32'd90, PH_MAX_BITS + 32'd1);
		send_reply(32'd100, NEG_ZERO);
		send_reply(32'd110, 32'h0000_0001);
		send_reply(32'd120, PH_MAX_BITS);
		// first start held off by cooldown from time zero
		send_tick(32'd29999);
		send_reply(32'd30000, 32'h0000_0000);
		send_reply(32'd34999, PH_MAX_BITS);
		send_tick(32'd35000);
		send_tick(32'd64999);
		send_tick(32'd65000);
		send_tick(32'd70000);
		// pH exactly on either band edge does not start the pump
		send_reply(32'd100000, 32'h40F0_0000);
		send_reply(32'd100001, 32'h40D0_0000);
		// run time across the timestamp wrap
		send_reply(32'hFFFF_FF00, PH_MAX_BITS);
		send_tick(32'h0000_1287);
		send_tick(32'h0000_1288);
		clock_ms = 32'h0000_1288;

		configure(24'd28672, 24'd2048, 24'd20, 24'd30);
		send_randoms(150, 32'd8);

		// receiver holds off long enough for the input side to back up
		rx_hold = 400;
		send_randoms(40, 32'd8);
		drain();

		configure(24'd0, 24'd0, 24'd0, 24'd0);
		send_randoms(80, 32'd3);

		configure(24'd57344, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF);
		send_randoms(60, 32'h0100_0000);

		configure(24'hFF_FFFF, 24'hFF_FFFF, 24'd1, 24'd1);
		send_randoms(60, 32'd2);

		// no idling on either side
		configure(24'($urandom_range(0, 57344)), 24'($urandom_range(0, 8192)),
			24'($urandom_range(1, 40)), 24'($urandom_range(0, 40)));
		idle_on = 1'b0;
		send_randoms(200, 32'd10);
		idle_on = 1'b1;

		configure(24'($urandom), 24'($urandom_range(0, 16384)),
			24'($urandom_range(0, 60)), 24'($urandom_range(0, 60)));
		send_randoms(260, 32'd12);

		drain();
		if (errors == 0 && pending == 0)
			$display("ph_dosing_pump_controller_tb: clean");
		else
			$display("ph_dosing_pump_controller_tb: errors");
		$finish;
	end

endmodule
